// ----- src/rgbc_pkg.sv -----
package rgbc_pkg;

  // Geometry and arithmetic sizes
  localparam int MAX_WIDTH      = 4096;
  localparam int ADDR_W         = $clog2(MAX_WIDTH);
  localparam int WIDTH_W        = 13;
  localparam int POS_W          = 12;
  localparam int COEF_FRAC_BITS = 12;
  localparam int CHANNEL_BITS   = 16;
  localparam int NUM_CH         = 3;
  localparam int NUM_TAPS       = 3;
  localparam int PIX_W          = NUM_CH * CHANNEL_BITS;
  localparam int TAP_W          = 16;
  localparam int COEF_W         = NUM_TAPS * TAP_W;
  localparam int PROD_W         = TAP_W + CHANNEL_BITS + 1;
  localparam int COLSUM_W       = PROD_W + 2;
  localparam int TOTAL_W        = COLSUM_W + 2;
  localparam int QUOT_W         = TOTAL_W - COEF_FRAC_BITS;
  localparam int CFG_IDX_W      = 3;

  localparam logic [POS_W-1:0]        ROW_LIMIT     = POS_W'(4095);
  localparam logic [CHANNEL_BITS-1:0] CHAN_MAX_8    = CHANNEL_BITS'(255);
  localparam logic [CHANNEL_BITS-1:0] CHAN_MAX_FULL = '1;
  localparam logic [WIDTH_W-1:0]      WIDTH_MIN     = WIDTH_W'(3);
  localparam logic [WIDTH_W-1:0]      WIDTH_MAX     = WIDTH_W'(MAX_WIDTH);

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEPTH_MODE  = 3'd0,
    CFG_IMAGE_WIDTH = 3'd1,
    CFG_COEF_LEFT   = 3'd2,
    CFG_COEF_CENTER = 3'd3,
    CFG_COEF_RIGHT  = 3'd4
  } cfg_index_t;

  typedef logic [PIX_W-1:0] pixel_t;
  typedef logic [COEF_W-1:0] coef_col_t;
  // Index 0 is the top row of the window column
  typedef logic [NUM_TAPS-1:0][PIX_W-1:0] pix_col_t;

  typedef struct packed {
    logic                    start_of_frame;
    logic [CHANNEL_BITS-1:0] red_in;
    logic [CHANNEL_BITS-1:0] green_in;
    logic [CHANNEL_BITS-1:0] blue_in;
  } in_item_t;

  typedef struct packed {
    logic [CHANNEL_BITS-1:0] red_out;
    logic [CHANNEL_BITS-1:0] green_out;
    logic [CHANNEL_BITS-1:0] blue_out;
    logic [POS_W-1:0]        out_column;
    logic [POS_W-1:0]        out_row;
  } out_item_t;

  // Stage enables handed to every window cell
  typedef struct packed {
    logic shift;
    logic mul_en;
    logic sum_en;
  } cell_ctrl_t;

endpackage

// ----- src/rgbc_line_store.sv -----
module rgbc_line_store
  import rgbc_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                rd_en,
  input  logic [ADDR_W-1:0]   rd_addr,
  input  logic                wr_en,
  input  logic [ADDR_W-1:0]   wr_addr,
  input  logic [2*PIX_W-1:0]  wr_data,
  output logic [2*PIX_W-1:0]  rd_data
);

  // Upper half: row two above, lower half: row above
  logic [2*PIX_W-1:0] mem [MAX_WIDTH];
  logic [2*PIX_W-1:0] rd_r;
  logic [2*PIX_W-1:0] byp_data_r;
  logic               byp_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_r       <= mem[rd_addr];
      byp_data_r <= wr_data;
    end
  end

  // Read and write of the same entry in one cycle: forward the new word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_r <= 1'b0;
    end else if (rd_en) begin
      byp_r <= wr_en && (wr_addr == rd_addr);
    end
  end

  assign rd_data = byp_r ? byp_data_r : rd_r;

endmodule

// ----- src/rgbc_cell.sv -----
module rgbc_cell
  import rgbc_pkg::*;
(
  input  logic                       clk,
  input  cell_ctrl_t                 ctrl,
  input  pix_col_t                   col_in,
  input  coef_col_t                  taps,
  output pix_col_t                   col_out,
  output logic signed [COLSUM_W-1:0] sum_out [NUM_CH]
);

  pix_col_t                   col_r;
  logic signed [PROD_W-1:0]   prod_nxt [NUM_TAPS][NUM_CH];
  logic signed [PROD_W-1:0]   prod_r   [NUM_TAPS][NUM_CH];
  logic signed [COLSUM_W-1:0] sum_nxt  [NUM_CH];
  logic signed [COLSUM_W-1:0] sum_r    [NUM_CH];

  // Window column, passed on to the left neighbor on each shift
  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      col_r <= col_in;
    end
  end

  // One signed tap times one unsigned sample per row and channel
  always_comb begin
    for (int r = 0; r < NUM_TAPS; r++) begin
      for (int c = 0; c < NUM_CH; c++) begin
        prod_nxt[r][c] = $signed(taps[r*TAP_W +: TAP_W])
                       * $signed({1'b0, col_r[r][c*CHANNEL_BITS +: CHANNEL_BITS]});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod_r <= prod_nxt;
    end
  end

  // Column sum per channel
  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      sum_nxt[c] = COLSUM_W'(prod_r[0][c]) + COLSUM_W'(prod_r[1][c])
                 + COLSUM_W'(prod_r[2][c]);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.sum_en) begin
      sum_r <= sum_nxt;
    end
  end

  assign col_out = col_r;
  assign sum_out = sum_r;

endmodule

// ----- src/rgb_3x3_convolution_clamp.sv -----
// 3x3 RGB convolution with clamp. Pixels enter in raster order, one per clock
// sustained barring output stalls; the line store reads one 96-bit word and
// writes one per pixel, and the window moves through a chain of three column
// cells, which set that rate. A result follows its window's last pixel through
// line store read, window, multiply, column sum, total and clamp. Border
// pixels give no result. Taps are signed Q3.12; each channel sum is floored
// and clamped to 255 (depth_mode 0) or 65535 (depth_mode 1). The line stores
// have no clearing pass: entries are valid once the first two rows of a frame
// have been written. Write configuration only while no pixel is in flight.
module rgb_3x3_convolution_clamp
  import rgbc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COEF_W-1:0]    cfg_data
);

  // Configuration registers
  logic               depth_mode_r;
  logic [WIDTH_W-1:0] image_width_r;
  coef_col_t          coef_r [NUM_TAPS];

  // Position counters
  logic [POS_W-1:0] col_r, row_r;
  logic [POS_W-1:0] col_cur, row_cur, col_nxt, row_nxt;
  logic [WIDTH_W-1:0] width_eff, col_inc;
  logic wrap, emit_cur, in_xact;

  // Stage valids and ready chain
  logic v1_r, v2_r, v3_r, v4_r, v5_r, out_valid_r;
  logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;

  // Stage payload
  pixel_t           s1_pix_r;
  logic [ADDR_W-1:0] s1_addr_r;
  logic             s1_emit_r;
  logic [POS_W-1:0] s1_col_r, s1_row_r, s2_col_r, s2_row_r, s3_col_r, s3_row_r;
  logic [POS_W-1:0] s4_col_r, s4_row_r, s5_col_r, s5_row_r;
  logic [2*PIX_W-1:0] ls_rd_data, ls_wr_data;
  logic               ls_wr_en;
  pixel_t             above, two_above;
  pix_col_t           cur_col;
  pix_col_t           cell_col [NUM_TAPS+1];
  logic signed [COLSUM_W-1:0] col_sum [NUM_TAPS][NUM_CH];
  logic signed [TOTAL_W-1:0]  total_nxt [NUM_CH];
  logic signed [TOTAL_W-1:0]  total_r   [NUM_CH];
  logic [CHANNEL_BITS-1:0]    chan_nxt  [NUM_CH];
  logic [QUOT_W-1:0]          quot      [NUM_CH];
  logic [QUOT_W-1:0]          limit;
  out_item_t                  out_nxt, out_r;
  cell_ctrl_t                 cell_ctrl;

  // Configuration writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_mode_r  <= 1'b0;
      image_width_r <= WIDTH_MAX;
      coef_r[0]     <= '0;
      coef_r[1]     <= COEF_W'(4096);
      coef_r[2]     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_DEPTH_MODE:  depth_mode_r  <= cfg_data[0];
        CFG_IMAGE_WIDTH: image_width_r <= cfg_data[WIDTH_W-1:0];
        CFG_COEF_LEFT:   coef_r[0]     <= cfg_data;
        CFG_COEF_CENTER: coef_r[1]     <= cfg_data;
        CFG_COEF_RIGHT:  coef_r[2]     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Ready chain: a stage loads when empty or when its content moves on
  assign rdy6     = !out_valid_r || out_ready;
  assign rdy5     = !v5_r || rdy6;
  assign rdy4     = !v4_r || rdy5;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;
  assign in_xact  = in_valid && in_ready;

  // Pixel position of the incoming transaction
  always_comb begin
    col_cur = in_data.start_of_frame ? '0 : col_r;
    row_cur = in_data.start_of_frame ? '0 : row_r;
    if (image_width_r < WIDTH_MIN) begin
      width_eff = WIDTH_MIN;
    end else if (image_width_r > WIDTH_MAX) begin
      width_eff = WIDTH_MAX;
    end else begin
      width_eff = image_width_r;
    end
    col_inc  = {1'b0, col_cur} + WIDTH_W'(1);
    wrap     = col_inc >= width_eff;
    col_nxt  = wrap ? '0 : col_inc[POS_W-1:0];
    row_nxt  = (wrap && row_cur != ROW_LIMIT) ? row_cur + POS_W'(1) : row_cur;
    emit_cur = (row_cur >= POS_W'(2)) && (col_cur >= POS_W'(2));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_xact) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // Stage 1: line store read in flight
  always_ff @(posedge clk) begin
    if (in_xact) begin
      s1_pix_r  <= {in_data.blue_in, in_data.green_in, in_data.red_in};
      s1_addr_r <= col_cur[ADDR_W-1:0];
      s1_emit_r <= emit_cur;
      s1_col_r  <= col_cur - POS_W'(1);
      s1_row_r  <= row_cur - POS_W'(1);
    end
  end

  assign ls_wr_en   = v1_r && rdy2;
  assign above      = ls_rd_data[PIX_W-1:0];
  assign two_above  = ls_rd_data[2*PIX_W-1:PIX_W];
  assign ls_wr_data = {above, s1_pix_r};

  rgbc_line_store u_line_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_xact),
    .rd_addr (col_cur[ADDR_W-1:0]),
    .wr_en   (ls_wr_en),
    .wr_addr (s1_addr_r),
    .wr_data (ls_wr_data),
    .rd_data (ls_rd_data)
  );

  // Window: chain of column cells, right cell takes the new column
  always_comb begin
    cur_col[0] = two_above;
    cur_col[1] = above;
    cur_col[2] = s1_pix_r;
  end

  assign cell_ctrl.shift  = ls_wr_en;
  assign cell_ctrl.mul_en = rdy3;
  assign cell_ctrl.sum_en = rdy4;
  assign cell_col[NUM_TAPS] = cur_col;

  for (genvar g = 0; g < NUM_TAPS; g++) begin : g_cell
    rgbc_cell u_cell (
      .clk     (clk),
      .ctrl    (cell_ctrl),
      .col_in  (cell_col[g+1]),
      .taps    (coef_r[g]),
      .col_out (cell_col[g]),
      .sum_out (col_sum[g])
    );
  end

  // Total over the three columns
  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      total_nxt[c] = TOTAL_W'(col_sum[0][c]) + TOTAL_W'(col_sum[1][c])
                   + TOTAL_W'(col_sum[2][c]);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      s2_col_r <= s1_col_r;
      s2_row_r <= s1_row_r;
    end
    if (rdy3) begin
      s3_col_r <= s2_col_r;
      s3_row_r <= s2_row_r;
    end
    if (rdy4) begin
      s4_col_r <= s3_col_r;
      s4_row_r <= s3_row_r;
    end
    if (rdy5) begin
      s5_col_r <= s4_col_r;
      s5_row_r <= s4_row_r;
      total_r  <= total_nxt;
    end
    if (rdy6) begin
      out_r <= out_nxt;
    end
  end

  // Floor to integer and clamp to the channel range
  assign limit = depth_mode_r ? QUOT_W'(CHAN_MAX_FULL) : QUOT_W'(CHAN_MAX_8);

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      quot[c] = total_r[c][TOTAL_W-1:COEF_FRAC_BITS];
      if (total_r[c] < 0) begin
        chan_nxt[c] = '0;
      end else if (quot[c] > limit) begin
        chan_nxt[c] = limit[CHANNEL_BITS-1:0];
      end else begin
        chan_nxt[c] = quot[c][CHANNEL_BITS-1:0];
      end
    end
    out_nxt.red_out    = chan_nxt[0];
    out_nxt.green_out  = chan_nxt[1];
    out_nxt.blue_out   = chan_nxt[2];
    out_nxt.out_column = s5_col_r;
    out_nxt.out_row    = s5_row_r;
  end

  // Stage valids; border pixels drop out after the window shift
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy1) v1_r        <= in_valid;
      if (rdy2) v2_r        <= v1_r && s1_emit_r;
      if (rdy3) v3_r        <= v2_r;
      if (rdy4) v4_r        <= v3_r;
      if (rdy5) v5_r        <= v4_r;
      if (rdy6) out_valid_r <= v5_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef NO_ASSERTIONS
  // 8-bit mode never reports a channel above 255
  a_clamp_8: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !depth_mode_r |->
      out_data.red_out <= CHAN_MAX_8 && out_data.green_out <= CHAN_MAX_8 &&
      out_data.blue_out <= CHAN_MAX_8)
    else $error("8-bit clamp violated");

  // Column advances by one inside a row
  a_col_step: assert property (@(posedge clk) disable iff (!rst_n)
    in_xact && !in_data.start_of_frame && !wrap |=> col_r == $past(col_r) + POS_W'(1))
    else $error("column position did not advance");

  // An empty pipeline always takes a transaction
  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !(v1_r || v2_r || v3_r || v4_r || v5_r || out_valid_r) |-> in_ready)
    else $error("empty pipeline stalls input");
`endif

endmodule
